// ===== rtl/ghp_pkg.sv =====
`default_nettype none
package ghp_pkg;

  localparam int SLOTS     = 128;
  localparam int GEN_BITS  = 32;
  localparam int IDX_W     = 7;
  localparam int CNT_W     = 8;
  localparam int HGEN_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;

  localparam logic [CNT_W-1:0]    SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0]    CNT_ONE   = CNT_W'(1);
  localparam logic [GEN_BITS-1:0] GEN_ONE   = GEN_BITS'(1);
  localparam logic [GEN_BITS-1:0] GEN_ZERO  = '0;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESOLVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/generational_handle_pool.sv =====
// A word is accepted when start is high and busy is low; its result is
// registered out of the EVAL state, or out of EVAL and then POP for an
// allocate that pops the free stack. busy holds off a new word until its
// result strobes, over the read-modify-write of generation memory and stack.
// The receiver cannot stall; each result is on the ports for one cycle only.
// Reset (synchronous, rst_n low) empties the pool; the memories are not cleared.
`default_nettype none
module generational_handle_pool (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ghp_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [ghp_pkg::IDX_W-1:0]      in_handle_index,
  input  wire logic [ghp_pkg::HGEN_W-1:0]     in_handle_generation,
  output logic                                out_strobe,
  output logic [ghp_pkg::STATUS_W-1:0]        out_status,
  output logic [ghp_pkg::IDX_W-1:0]           out_slot_index,
  output logic [ghp_pkg::HGEN_W-1:0]          out_slot_generation,
  output logic                                out_handle_ok
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [ghp_pkg::FUNC_W-1:0] func_r;
  logic [ghp_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [ghp_pkg::HGEN_W-1:0] hgen_r;
  logic [ghp_pkg::CNT_W-1:0]  free_count_r, free_count_nxt;
  logic [ghp_pkg::CNT_W-1:0]  issued_count_r, issued_count_nxt;
  logic [ghp_pkg::CNT_W-1:0]  fc_dec;

  logic [ghp_pkg::GEN_BITS-1:0] gen_mem_r [ghp_pkg::SLOTS];
  logic [ghp_pkg::GEN_BITS-1:0] gen_rdata_r;
  logic [ghp_pkg::IDX_W-1:0]    gen_raddr, gen_waddr;
  logic [ghp_pkg::GEN_BITS-1:0] gen_wdata;
  logic                         gen_we;

  logic [ghp_pkg::IDX_W-1:0] stk_mem_r [ghp_pkg::SLOTS];
  logic [ghp_pkg::IDX_W-1:0] stk_rdata_r;
  logic [ghp_pkg::IDX_W-1:0] stk_raddr, stk_waddr;
  logic                      stk_we;

  logic                          strobe_r, strobe_nxt;
  logic [ghp_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [ghp_pkg::IDX_W-1:0]     oidx_r, oidx_nxt;
  logic [ghp_pkg::HGEN_W-1:0]    ogen_r, ogen_nxt;
  logic                          ok_r, ok_nxt;

  logic accept;
  logic handle_valid;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign fc_dec = free_count_r - ghp_pkg::CNT_ONE;

  assign handle_valid = ({1'b0, idx_r} < issued_count_r) &&
                        (ghp_pkg::HGEN_W'(gen_rdata_r) == hgen_r);

  assign gen_raddr = (state_r == S_EVAL) ? stk_rdata_r : in_handle_index;
  assign stk_raddr = fc_dec[ghp_pkg::IDX_W-1:0];
  assign stk_waddr = free_count_r[ghp_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem_r[gen_waddr] <= gen_wdata;
    end
    gen_rdata_r <= gen_mem_r[gen_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem_r[stk_waddr] <= idx_r;
    end
    stk_rdata_r <= stk_mem_r[stk_raddr];
  end

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    free_count_nxt   = free_count_r;
    issued_count_nxt = issued_count_r;
    gen_we           = 1'b0;
    gen_waddr        = idx_r;
    gen_wdata        = ghp_pkg::GEN_ZERO;
    stk_we           = 1'b0;
    strobe_nxt       = 1'b0;
    status_nxt       = ghp_pkg::ST_INVALID;
    oidx_nxt         = idx_r;
    ogen_nxt         = '0;
    ok_nxt           = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EVAL;
          idx_nxt   = in_handle_index;
        end
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        case (func_r)
          ghp_pkg::FUNC_ALLOC: begin
            if (free_count_r != '0) begin
              free_count_nxt = fc_dec;
              idx_nxt        = stk_rdata_r;
              state_nxt      = S_POP;
            end else if (issued_count_r < ghp_pkg::SLOTS_CNT) begin
              gen_we           = 1'b1;
              gen_waddr        = issued_count_r[ghp_pkg::IDX_W-1:0];
              issued_count_nxt = issued_count_r + ghp_pkg::CNT_ONE;
              strobe_nxt       = 1'b1;
              status_nxt       = ghp_pkg::ST_OK;
              oidx_nxt         = issued_count_r[ghp_pkg::IDX_W-1:0];
              ok_nxt           = 1'b1;
            end else begin
              strobe_nxt = 1'b1;
              status_nxt = ghp_pkg::ST_FULL;
              oidx_nxt   = '0;
            end
          end
          ghp_pkg::FUNC_RELEASE: begin
            strobe_nxt = 1'b1;
            if (handle_valid && (free_count_r < ghp_pkg::SLOTS_CNT)) begin
              gen_we         = 1'b1;
              gen_wdata      = gen_rdata_r + ghp_pkg::GEN_ONE;
              stk_we         = 1'b1;
              free_count_nxt = free_count_r + ghp_pkg::CNT_ONE;
              status_nxt     = ghp_pkg::ST_OK;
              ok_nxt         = 1'b1;
            end
          end
          ghp_pkg::FUNC_RESOLVE: begin
            strobe_nxt = 1'b1;
            if (handle_valid) begin
              status_nxt = ghp_pkg::ST_OK;
              ok_nxt     = 1'b1;
            end
          end
          default: begin
            strobe_nxt = 1'b1;
          end
        endcase
      end
      S_POP: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        status_nxt = ghp_pkg::ST_OK;
        ogen_nxt   = ghp_pkg::HGEN_W'(gen_rdata_r);
        ok_nxt     = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      free_count_r   <= '0;
      issued_count_r <= '0;
      strobe_r       <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      free_count_r   <= free_count_nxt;
      issued_count_r <= issued_count_nxt;
      strobe_r       <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    oidx_r   <= oidx_nxt;
    ogen_r   <= ogen_nxt;
    ok_r     <= ok_nxt;
    if (accept) begin
      func_r <= in_func;
      hgen_r <= in_handle_generation;
    end
  end

  assign out_strobe          = strobe_r;
  assign out_status          = status_r;
  assign out_slot_index      = oidx_r;
  assign out_slot_generation = ogen_r;
  assign out_handle_ok       = ok_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy did not rise after an accepted word");

  a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> ($past(state_r) == S_EVAL || $past(state_r) == S_POP))
    else $error("result strobe without a word in progress");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && ok_r) |-> (status_r == ghp_pkg::ST_OK))
    else $error("handle_ok with a failing status");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (free_count_r <= ghp_pkg::SLOTS_CNT) && (issued_count_r <= ghp_pkg::SLOTS_CNT))
    else $error("pool counter beyond the slot count");

endmodule
`default_nettype wire
